### hw/rtl/npr_pkg.sv
package npr_pkg;

  localparam int FRAC_BITS_DEF  = 10;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int COORD_W = 10;
  localparam int REG_W   = 12;
  localparam int SIZE_W  = 9;
  localparam int PIX_W   = 4;
  localparam int IDX_W   = 4;
  // dx = coord - center spans -2047..3071.
  localparam int DIFF_W  = 13;
  localparam int PROD_W  = DIFF_W + REG_W;
  localparam int SUM_W   = PROD_W + 2;

  // Queue between the front and the back.
  localparam int QDEPTH   = 8;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  // Requests that can be in the front pipeline, including the one being accepted.
  localparam int INFLIGHT = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_COS      = 4'd0,
    REG_SIN      = 4'd1,
    REG_DCX      = 4'd2,
    REG_DCY      = 4'd3,
    REG_SCX      = 4'd4,
    REG_SCY      = 4'd5,
    REG_SRC_W    = 4'd6,
    REG_SRC_H    = 4'd7
  } reg_idx_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_FETCH = 1'b1
  } act_t;

  typedef struct packed {
    act_t             action;
    logic             hit;
    logic             use_mask;
    logic [PIX_W-1:0] pixel;
    logic             transparent;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic nearly_full;
  } qstat_t;

endpackage

### hw/rtl/npr_front.sv
module npr_front #(
  parameter int FRAC_BITS  = npr_pkg::FRAC_BITS_DEF,
  parameter int MAX_WIDTH  = npr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = npr_pkg::MAX_HEIGHT_DEF,
  parameter int XW         = $clog2(MAX_WIDTH),
  parameter int YW         = $clog2(MAX_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [npr_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [npr_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [npr_pkg::PIX_W-1:0]     in_load_pixel,
  input  logic                          in_load_transparent,
  input  logic                          in_use_mask,
  input  logic                          cfg_valid,
  input  logic [npr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [npr_pkg::REG_W-1:0]     cfg_data,
  input  npr_pkg::qstat_t               qstat,
  output logic                          push,
  output npr_pkg::ctl_t                 push_ctl,
  output logic [XW+YW-1:0]              push_addr
);

  localparam int AW = XW + YW;

  logic signed [npr_pkg::REG_W-1:0] cos_r, sin_r, dcx_r, dcy_r, scx_r, scy_r;
  logic [npr_pkg::SIZE_W-1:0]       src_w_r, src_h_r;

  logic                              accept;
  logic                              v1_r, v2_r, v3_r;
  npr_pkg::ctl_t                     c1_r, c2_r, c3_r;
  logic [AW-1:0]                     a1_r, a2_r, a3_r;
  logic signed [npr_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic signed [npr_pkg::PROD_W-1:0] xc_r, xs_r, yc_r, ys_r;
  logic signed [npr_pkg::SUM_W-1:0]  su_r, sv_r;

  npr_pkg::ctl_t                     c1_nxt;
  logic [AW-1:0]                     a1_nxt;
  logic signed [npr_pkg::DIFF_W-1:0] dx_nxt, dy_nxt;
  logic signed [npr_pkg::SUM_W-1:0]  sx, sy;
  logic [npr_pkg::SIZE_W-1:0]        w_clamp, h_clamp;
  logic                              in_src;

  assign busy   = qstat.nearly_full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= npr_pkg::REG_W'(1024);
      sin_r   <= '0;
      dcx_r   <= '0;
      dcy_r   <= '0;
      scx_r   <= '0;
      scy_r   <= '0;
      src_w_r <= npr_pkg::SIZE_W'(256);
      src_h_r <= npr_pkg::SIZE_W'(256);
    end else if (cfg_valid) begin
      case (npr_pkg::reg_idx_t'(cfg_index))
        npr_pkg::REG_COS:   cos_r   <= cfg_data;
        npr_pkg::REG_SIN:   sin_r   <= cfg_data;
        npr_pkg::REG_DCX:   dcx_r   <= cfg_data;
        npr_pkg::REG_DCY:   dcy_r   <= cfg_data;
        npr_pkg::REG_SCX:   scx_r   <= cfg_data;
        npr_pkg::REG_SCY:   scy_r   <= cfg_data;
        npr_pkg::REG_SRC_W: src_w_r <= cfg_data[npr_pkg::SIZE_W-1:0];
        npr_pkg::REG_SRC_H: src_h_r <= cfg_data[npr_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: offsets from the destination center, and the store address for loads.
  always_comb begin
    dx_nxt = npr_pkg::DIFF_W'($signed({1'b0, in_coord_x})) - npr_pkg::DIFF_W'(dcx_r);
    dy_nxt = npr_pkg::DIFF_W'($signed({1'b0, in_coord_y})) - npr_pkg::DIFF_W'(dcy_r);
    c1_nxt.action      = npr_pkg::act_t'(in_action);
    c1_nxt.hit         = (32'(in_coord_x) < MAX_WIDTH) && (32'(in_coord_y) < MAX_HEIGHT);
    c1_nxt.use_mask    = in_use_mask;
    c1_nxt.pixel       = in_load_pixel;
    c1_nxt.transparent = in_load_transparent;
    a1_nxt             = {YW'(in_coord_y), XW'(in_coord_x)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      c1_r <= c1_nxt;
      a1_r <= a1_nxt;
    end
    // Stage 2: the four rotation products.
    xc_r <= npr_pkg::PROD_W'(dx_r) * npr_pkg::PROD_W'(cos_r);
    xs_r <= npr_pkg::PROD_W'(dx_r) * npr_pkg::PROD_W'(sin_r);
    yc_r <= npr_pkg::PROD_W'(dy_r) * npr_pkg::PROD_W'(cos_r);
    ys_r <= npr_pkg::PROD_W'(dy_r) * npr_pkg::PROD_W'(sin_r);
    c2_r <= c1_r;
    a2_r <= a1_r;
    // Stage 3: rotated offsets, still carrying the fraction bits.
    su_r <= npr_pkg::SUM_W'(xc_r) + npr_pkg::SUM_W'(ys_r);
    sv_r <= npr_pkg::SUM_W'(yc_r) - npr_pkg::SUM_W'(xs_r);
    c3_r <= c2_r;
    a3_r <= a2_r;
  end

  // Stage 4: floor by arithmetic shift, move to the source center and bound check.
  always_comb begin
    w_clamp = (32'(src_w_r) > MAX_WIDTH)  ? npr_pkg::SIZE_W'(MAX_WIDTH)  : src_w_r;
    h_clamp = (32'(src_h_r) > MAX_HEIGHT) ? npr_pkg::SIZE_W'(MAX_HEIGHT) : src_h_r;
    sx = (su_r >>> FRAC_BITS) + npr_pkg::SUM_W'(scx_r);
    sy = (sv_r >>> FRAC_BITS) + npr_pkg::SUM_W'(scy_r);
    in_src = !sx[npr_pkg::SUM_W-1] && !sy[npr_pkg::SUM_W-1]
          && (sx < npr_pkg::SUM_W'($signed({1'b0, w_clamp})))
          && (sy < npr_pkg::SUM_W'($signed({1'b0, h_clamp})));
    push     = v3_r;
    push_ctl = c3_r;
    push_addr = a3_r;
    if (c3_r.action == npr_pkg::ACT_FETCH) begin
      push_ctl.hit = in_src;
      push_addr    = {sy[YW-1:0], sx[XW-1:0]};
    end
  end

endmodule

### hw/rtl/npr_queue.sv
module npr_queue #(
  parameter int AW = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  npr_pkg::ctl_t   push_ctl,
  input  logic [AW-1:0]   push_addr,
  input  logic            pop,
  output npr_pkg::ctl_t   head_ctl,
  output logic [AW-1:0]   head_addr,
  output npr_pkg::qstat_t qstat
);

  localparam int EW = $bits(npr_pkg::ctl_t) + AW;

  logic [EW-1:0]               slot_r [npr_pkg::QDEPTH];
  logic [npr_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [npr_pkg::QCNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= {push_ctl, push_addr};
    end
  end

  assign {head_ctl, head_addr} = slot_r[rd_ptr_r];
  assign qstat.empty       = (count_r == '0);
  // Leaves room for every request that may still be in the front pipeline.
  assign qstat.nearly_full =
      (count_r >= npr_pkg::QCNT_W'(npr_pkg::QDEPTH - npr_pkg::INFLIGHT));

endmodule

### hw/rtl/npr_back.sv
module npr_back #(
  parameter int AW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  npr_pkg::qstat_t             qstat,
  input  npr_pkg::ctl_t               head_ctl,
  input  logic [AW-1:0]               head_addr,
  output logic                        pop,
  output logic                        out_valid,
  output logic [npr_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_transparent_out
);

  // Each word holds the nibble in the low bits and the transparency bit on top.
  logic [npr_pkg::PIX_W:0] store_r [2**AW];
  logic [npr_pkg::PIX_W:0] rd_r;
  logic                    fetch_r, hit_r, use_mask_r;
  logic                    show;

  assign pop = !qstat.empty;

  always_ff @(posedge clk) begin
    if (pop && head_ctl.action == npr_pkg::ACT_LOAD && head_ctl.hit) begin
      store_r[head_addr] <= {head_ctl.transparent, head_ctl.pixel};
    end
    rd_r       <= store_r[head_addr];
    hit_r      <= head_ctl.hit;
    use_mask_r <= head_ctl.use_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_r <= 1'b0;
    end else begin
      fetch_r <= pop && (head_ctl.action == npr_pkg::ACT_FETCH);
    end
  end

  assign show                = hit_r && !(use_mask_r && rd_r[npr_pkg::PIX_W]);
  assign out_valid           = fetch_r;
  assign out_pixel_out       = show ? rd_r[npr_pkg::PIX_W-1:0] : '0;
  assign out_transparent_out = !show;

endmodule

### hw/rtl/nibble_pixelmap_rotate_nearest.sv
// Channel   Handshake                  Payload
// in        start / busy               in_action, in_coord_x, in_coord_y, in_load_pixel,
//                                      in_load_transparent, in_use_mask
// out       out_valid (strobe)         out_pixel_out, out_transparent_out
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One request per cycle is accepted while busy is low. A fetch result reaches the out
// ports through three front register stages (offset, multiply, sum), one queue
// slot and the registered read of the source store. The bound check sits in front of
// the queue. A load produces no result.
// Reset is synchronous, clears the control state and loads the register defaults;
// the source store is not cleared. The back drains the queue every cycle, so busy
// only rises if the queue ever nears full, and results are never held back.
module nibble_pixelmap_rotate_nearest #(
  parameter int FRAC_BITS  = npr_pkg::FRAC_BITS_DEF,
  parameter int MAX_WIDTH  = npr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = npr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [npr_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [npr_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [npr_pkg::PIX_W-1:0]     in_load_pixel,
  input  logic                          in_load_transparent,
  input  logic                          in_use_mask,
  output logic                          out_valid,
  output logic [npr_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                          out_transparent_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [npr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [npr_pkg::REG_W-1:0]     cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  npr_pkg::qstat_t qstat;
  npr_pkg::ctl_t   push_ctl, head_ctl;
  logic [AW-1:0]   push_addr, head_addr;
  logic            push, pop;

  assign cfg_ready = 1'b1;

  npr_front #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_load_pixel       (in_load_pixel),
    .in_load_transparent (in_load_transparent),
    .in_use_mask         (in_use_mask),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .qstat               (qstat),
    .push                (push),
    .push_ctl            (push_ctl),
    .push_addr           (push_addr)
  );

  npr_queue #(
    .AW (AW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_addr (push_addr),
    .pop       (pop),
    .head_ctl  (head_ctl),
    .head_addr (head_addr),
    .qstat     (qstat)
  );

  npr_back #(
    .AW (AW)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .qstat               (qstat),
    .head_ctl            (head_ctl),
    .head_addr           (head_addr),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_pixel_out       (out_pixel_out),
    .out_transparent_out (out_transparent_out)
  );

endmodule

### dv/tb_nibble_pixelmap_rotate_nearest.sv
module tb_nibble_pixelmap_rotate_nearest;
  import npr_pkg::*;

  localparam int NUM_REGS     = 8;
  localparam int FIX_ONE      = 1 << FRAC_BITS_DEF;
  localparam int REG_MIN      = -(1 << (REG_W - 1));
  localparam int REG_MAX      = (1 << (REG_W - 1)) - 1;
  localparam int SIZE_MAX     = (1 << SIZE_W) - 1;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int PIX_MAX      = (1 << PIX_W) - 1;
  localparam int STORE_DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEM_TARGET  = 850;
  localparam int CYCLE_LIMIT  = 500000;

  // Kinds of register setting applied between phases.
  localparam int SET_RANDOM    = 0;
  localparam int SET_LOW       = 1;
  localparam int SET_HIGH      = 2;
  localparam int SET_WILD      = 3;
  localparam int SET_NO_WIDTH  = 4;
  localparam int SET_NO_HEIGHT = 5;
  localparam int NUM_FIXED     = 5;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             transparent;
  } rot_result_t;

  class rotate_scoreboard;
    logic [REG_W-1:0] regs [NUM_REGS];
    logic [PIX_W-1:0] src_pixels [STORE_DEPTH];
    bit               src_mask [STORE_DEPTH];
    bit               loaded [STORE_DEPTH];
    rot_result_t      expected_pixels [$];
    int               mismatches;

    function new();
      regs[REG_COS]   = REG_W'(FIX_ONE);
      regs[REG_SIN]   = '0;
      regs[REG_DCX]   = '0;
      regs[REG_DCY]   = '0;
      regs[REG_SCX]   = '0;
      regs[REG_SCY]   = '0;
      regs[REG_SRC_W] = REG_W'(MAX_WIDTH_DEF);
      regs[REG_SRC_H] = REG_W'(MAX_HEIGHT_DEF);
      mismatches = 0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
      if (idx < NUM_REGS) begin
        regs[idx] = data;
      end
    endfunction

    // Rotates a destination pixel back into the source and reports whether it lands
    // inside the (clamped) source rectangle.
    function bit map_to_source(int x, int y, output int sx, output int sy);
      longint cosv;
      longint sinv;
      longint dx;
      longint dy;
      int     w;
      int     h;
      cosv = longint'($signed(regs[REG_COS]));
      sinv = longint'($signed(regs[REG_SIN]));
      dx = longint'(x) - longint'($signed(regs[REG_DCX]));
      dy = longint'(y) - longint'($signed(regs[REG_DCY]));
      sx = int'((dx * cosv + dy * sinv) >>> FRAC_BITS_DEF) + int'($signed(regs[REG_SCX]));
      sy = int'((dy * cosv - dx * sinv) >>> FRAC_BITS_DEF) + int'($signed(regs[REG_SCY]));
      w = int'(regs[REG_SRC_W][SIZE_W-1:0]);
      h = int'(regs[REG_SRC_H][SIZE_W-1:0]);
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      return sx >= 0 && sx < w && sy >= 0 && sy < h;
    endfunction

    // True when a fetch of (x, y) would read a source entry that was never loaded.
    function bit needs_fill(int x, int y, output int sx, output int sy);
      if (!map_to_source(x, y, sx, sy)) return 1'b0;
      return !loaded[sy * MAX_WIDTH_DEF + sx];
    endfunction

    function void note_request(act_t act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               logic [PIX_W-1:0] pix, logic tr, logic um);
      int          sx;
      int          sy;
      int          addr;
      rot_result_t res;
      if (act == ACT_LOAD) begin
        if (x < MAX_WIDTH_DEF && y < MAX_HEIGHT_DEF) begin
          addr = int'(y) * MAX_WIDTH_DEF + int'(x);
          src_pixels[addr] = pix;
          src_mask[addr] = tr;
          loaded[addr] = 1'b1;
        end
        return;
      end
      res.pixel = '0;
      res.transparent = 1'b1;
      if (map_to_source(int'(x), int'(y), sx, sy)) begin
        addr = sy * MAX_WIDTH_DEF + sx;
        if (!(um && src_mask[addr])) begin
          res.pixel = src_pixels[addr];
          res.transparent = 1'b0;
        end
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic tr);
      rot_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out %0d, transparent_out %0d", pix, tr);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (pix !== want.pixel) begin
        $error("pixel_out: expected %0d, got %0d", want.pixel, pix);
        mismatches++;
      end
      if (tr !== want.transparent) begin
        $error("transparent_out: expected %0d, got %0d", want.transparent, tr);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = ACT_LOAD;
  logic [COORD_W-1:0] in_coord_x = '0;
  logic [COORD_W-1:0] in_coord_y = '0;
  logic [PIX_W-1:0]   in_load_pixel = '0;
  logic               in_load_transparent = 1'b0;
  logic               in_use_mask = 1'b0;
  logic               out_valid;
  logic [PIX_W-1:0]   out_pixel_out;
  logic               out_transparent_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [REG_W-1:0]   cfg_data = '0;

  rotate_scoreboard sb = new();

  int items_done = 0;
  bit no_gaps = 1'b0;
  int cur_dcx = 0;
  int cur_dcy = 0;
  int cur_w = MAX_WIDTH_DEF;
  int cur_h = MAX_HEIGHT_DEF;

  nibble_pixelmap_rotate_nearest i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_load_pixel       (in_load_pixel),
    .in_load_transparent (in_load_transparent),
    .in_use_mask         (in_use_mask),
    .out_valid           (out_valid),
    .out_pixel_out       (out_pixel_out),
    .out_transparent_out (out_transparent_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_pixel_out, out_transparent_out);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_nibble_pixelmap_rotate_nearest: errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int clamp_size(logic [REG_W-1:0] v, int cap);
    int s;
    s = int'(v[SIZE_W-1:0]);
    return (s > cap) ? cap : s;
  endfunction

  // Start stays high from one request to the next unless a gap is inserted.
  task automatic push_req(act_t act, int x, int y, logic [PIX_W-1:0] pix, logic tr,
                          logic um);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_coord_x <= COORD_W'(x);
    in_coord_y <= COORD_W'(y);
    in_load_pixel <= pix;
    in_load_transparent <= tr;
    in_use_mask <= um;
    do @(posedge clk); while (busy);
    sb.note_request(act, COORD_W'(x), COORD_W'(y), pix, tr, um);
    if (!(act == ACT_LOAD && (x >= MAX_WIDTH_DEF || y >= MAX_HEIGHT_DEF))) items_done++;
  endtask

  // A fetch that would land on a never-loaded source pixel is preceded by a load there.
  task automatic push_fetch(int x, int y, logic um);
    int sx;
    int sy;
    if (sb.needs_fill(x, y, sx, sy)) begin
      push_req(ACT_LOAD, sx, sy, PIX_W'($urandom), 1'($urandom), 1'($urandom));
    end
    push_req(ACT_FETCH, x, y, PIX_W'($urandom), 1'($urandom), um);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
  endtask

  task automatic apply_setting(int kind);
    logic [REG_W-1:0] vals [NUM_REGS];
    int               a;
    int               r;
    case (kind)
      SET_LOW: begin
        vals[REG_COS] = REG_W'(-FIX_ONE);
        vals[REG_SIN] = REG_W'(FIX_ONE);
        vals[REG_DCX] = REG_W'(REG_MIN);
        vals[REG_DCY] = REG_W'(REG_MIN);
        vals[REG_SCX] = REG_W'(REG_MIN);
        vals[REG_SCY] = REG_W'(REG_MIN);
        vals[REG_SRC_W] = REG_W'(1);
        vals[REG_SRC_H] = REG_W'(1);
      end
      SET_HIGH: begin
        vals[REG_COS] = REG_W'(FIX_ONE);
        vals[REG_SIN] = REG_W'(-FIX_ONE);
        vals[REG_DCX] = REG_W'(REG_MAX);
        vals[REG_DCY] = REG_W'(REG_MAX);
        vals[REG_SCX] = REG_W'(REG_MAX);
        vals[REG_SCY] = REG_W'(REG_MAX);
        vals[REG_SRC_W] = REG_W'(MAX_WIDTH_DEF);
        vals[REG_SRC_H] = REG_W'(MAX_HEIGHT_DEF);
      end
      SET_WILD: begin
        // Out-of-range trig values and sizes above the store, which clamp.
        vals[REG_COS] = REG_W'(REG_MAX);
        vals[REG_SIN] = REG_W'(REG_MIN);
        vals[REG_DCX] = REG_W'(COORD_MAX / 2);
        vals[REG_DCY] = REG_W'(COORD_MAX / 2);
        vals[REG_SCX] = REG_W'(MAX_WIDTH_DEF / 2);
        vals[REG_SCY] = REG_W'(MAX_HEIGHT_DEF / 2);
        vals[REG_SRC_W] = '1;
        vals[REG_SRC_H] = REG_W'(MAX_HEIGHT_DEF + 1);
      end
      SET_NO_WIDTH, SET_NO_HEIGHT: begin
        vals[REG_COS] = REG_W'(FIX_ONE);
        vals[REG_SIN] = '0;
        vals[REG_DCX] = REG_W'($urandom_range(0, MAX_WIDTH_DEF - 1));
        vals[REG_DCY] = REG_W'($urandom_range(0, MAX_HEIGHT_DEF - 1));
        vals[REG_SCX] = vals[REG_DCX];
        vals[REG_SCY] = vals[REG_DCY];
        vals[REG_SRC_W] = (kind == SET_NO_WIDTH) ? '0 : REG_W'(SIZE_MAX);
        vals[REG_SRC_H] = (kind == SET_NO_HEIGHT) ? '0 : REG_W'(MAX_HEIGHT_DEF);
      end
      default: begin
        a = $urandom_range(0, 5);
        case (a)
          0: begin vals[REG_COS] = REG_W'(FIX_ONE);  vals[REG_SIN] = '0; end
          1: begin vals[REG_COS] = '0;               vals[REG_SIN] = REG_W'(FIX_ONE); end
          2: begin vals[REG_COS] = REG_W'(-FIX_ONE); vals[REG_SIN] = '0; end
          3: begin vals[REG_COS] = '0;               vals[REG_SIN] = REG_W'(-FIX_ONE); end
          4: begin
            vals[REG_COS] = REG_W'(int'($urandom_range(0, 2 * FIX_ONE)) - FIX_ONE);
            vals[REG_SIN] = REG_W'(int'($urandom_range(0, 2 * FIX_ONE)) - FIX_ONE);
          end
          default: begin
            vals[REG_COS] = REG_W'($urandom);
            vals[REG_SIN] = REG_W'($urandom);
          end
        endcase
        // Mostly small sources, so fetches keep landing on loaded pixels.
        r = $urandom_range(0, 9);
        if (r < 7) begin
          vals[REG_SRC_W] = REG_W'($urandom_range(1, 24));
          vals[REG_SRC_H] = REG_W'($urandom_range(1, 24));
        end else if (r < 9) begin
          vals[REG_SRC_W] = REG_W'($urandom_range(25, MAX_WIDTH_DEF));
          vals[REG_SRC_H] = REG_W'($urandom_range(25, MAX_HEIGHT_DEF));
        end else begin
          vals[REG_SRC_W] = REG_W'($urandom);
          vals[REG_SRC_H] = REG_W'($urandom);
        end
        cur_w = clamp_size(vals[REG_SRC_W], MAX_WIDTH_DEF);
        cur_h = clamp_size(vals[REG_SRC_H], MAX_HEIGHT_DEF);
        vals[REG_SCX] = (cur_w > 0 && $urandom_range(0, 7) != 0) ?
                        REG_W'($urandom_range(0, cur_w - 1)) : REG_W'($urandom);
        vals[REG_SCY] = (cur_h > 0 && $urandom_range(0, 7) != 0) ?
                        REG_W'($urandom_range(0, cur_h - 1)) : REG_W'($urandom);
        vals[REG_DCX] = ($urandom_range(0, 7) != 0) ?
                        REG_W'($urandom_range(0, COORD_MAX)) : REG_W'($urandom);
        vals[REG_DCY] = ($urandom_range(0, 7) != 0) ?
                        REG_W'($urandom_range(0, COORD_MAX)) : REG_W'($urandom);
      end
    endcase
    cur_w = clamp_size(vals[REG_SRC_W], MAX_WIDTH_DEF);
    cur_h = clamp_size(vals[REG_SRC_H], MAX_HEIGHT_DEF);
    cur_dcx = int'($signed(vals[REG_DCX]));
    cur_dcy = int'($signed(vals[REG_DCY]));
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write(IDX_W'(i), vals[i]);
    end
    // Writes to unused indexes must leave every register alone.
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1)), REG_W'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int n;
    int reach;
    int x;
    int y;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting is the identity over the full store.
    push_req(ACT_LOAD, 0, 0, PIX_W'(PIX_MAX), 1'b0, 1'b0);
    push_req(ACT_LOAD, MAX_WIDTH_DEF - 1, MAX_HEIGHT_DEF - 1, '0, 1'b1, 1'b1);
    push_req(ACT_LOAD, MAX_WIDTH_DEF - 1, 0, PIX_W'(5), 1'b1, 1'b0);
    push_req(ACT_LOAD, 0, MAX_HEIGHT_DEF - 1, PIX_W'(10), 1'b0, 1'b1);
    // Loads beyond the store are dropped.
    push_req(ACT_LOAD, MAX_WIDTH_DEF, 7, PIX_W'(9), 1'b0, 1'b0);
    push_req(ACT_LOAD, COORD_MAX, COORD_MAX, PIX_W'(PIX_MAX), 1'b1, 1'b1);
    push_fetch(0, 0, 1'b0);
    push_fetch(0, 0, 1'b1);
    push_fetch(MAX_WIDTH_DEF - 1, MAX_HEIGHT_DEF - 1, 1'b0);
    push_fetch(MAX_WIDTH_DEF - 1, MAX_HEIGHT_DEF - 1, 1'b1);
    push_fetch(MAX_WIDTH_DEF - 1, 0, 1'b1);
    push_fetch(MAX_WIDTH_DEF - 1, 0, 1'b0);
    push_fetch(0, MAX_HEIGHT_DEF - 1, 1'b1);
    push_fetch(MAX_WIDTH_DEF, 0, 1'b1);
    push_fetch(0, MAX_HEIGHT_DEF, 1'b0);
    push_fetch(COORD_MAX, COORD_MAX, 1'b0);
    // Overwrite followed at once by reads of the same pixel.
    push_req(ACT_LOAD, 0, 0, PIX_W'(3), 1'b1, 1'b0);
    push_fetch(0, 0, 1'b1);
    push_fetch(0, 0, 1'b0);

    phase = 0;
    while (items_done < ITEM_TARGET) begin
      drain();
      apply_setting((phase < NUM_FIXED) ? phase + 1 : SET_RANDOM);
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(30, 80);
      reach = ((cur_w > cur_h) ? cur_w : cur_h) + 2;
      repeat (n) begin
        if ($urandom_range(0, 99) < 30) begin
          if (cur_w > 0 && cur_h > 0 && $urandom_range(0, 3) != 0) begin
            x = $urandom_range(0, cur_w - 1);
            y = $urandom_range(0, cur_h - 1);
          end else begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
          end
          push_req(ACT_LOAD, x, y, PIX_W'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(0, 4) == 0) begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
          end else begin
            x = clamp_coord(cur_dcx + int'($urandom_range(0, 2 * reach)) - reach);
            y = clamp_coord(cur_dcy + int'($urandom_range(0, 2 * reach)) - reach);
          end
          push_fetch(x, y, 1'($urandom));
        end
      end
      phase++;
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_nibble_pixelmap_rotate_nearest: clean");
    end else begin
      $display("tb_nibble_pixelmap_rotate_nearest: errors");
    end
    $finish;
  end

endmodule
